[rtl/core/dlte_pkg.sv]
// ----------------------------------------------------------------------------
// dlte_pkg: shared types and constants for the dense layer training engine
// Layer sizes, fixed-point format, action and result codes, control structs.
// ----------------------------------------------------------------------------
package dlte_pkg;

    localparam int IN_DIM    = 16;
    localparam int OUT_DIM   = 16;
    localparam int FRAC_BITS = 16;
    localparam int LR_FRAC   = 16;
    localparam int LR_W      = 20;
    localparam int NW        = IN_DIM * OUT_DIM;

    // storage indexes and the shared loop counter
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int RIW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int CIW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
    localparam int CW  = $clog2(NW + OUT_DIM + 1);

    typedef enum logic [2:0] {
        ACT_WR_W = 3'd0,
        ACT_WR_B = 3'd1,
        ACT_FWD  = 3'd2,
        ACT_LOAD = 3'd3,
        ACT_BWD  = 3'd4,
        ACT_UPD  = 3'd5,
        ACT_RD_W = 3'd6,
        ACT_RD_B = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        KIND_OUT   = 3'd0,
        KIND_IGRAD = 3'd1,
        KIND_WRD   = 3'd2,
        KIND_BRD   = 3'd3,
        KIND_DONE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OP_FWD = 2'd0,
        OP_BWD = 2'd1,
        OP_UPD = 2'd2,
        OP_CLR = 2'd3
    } loop_op_t;

    // controller to datapath
    typedef struct packed {
        logic            latch;
        logic            dispatch;
        logic            issue;
        loop_op_t        op;
        logic [CW-1:0]   idx;
        logic            emit;
        kind_t           kind;
        logic            emit_end;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t action;
        logic    last;
        logic    rok;
        logic    cok;
        logic    out_free;
    } status_t;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/core/dlte_ctrl.sv]
// ----------------------------------------------------------------------------
// dlte_ctrl: sequencer for the dense layer training engine
// Dispatches each request, steps the loop counter and paces result emission.
// ----------------------------------------------------------------------------
module dlte_ctrl
    import dlte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_LOOP,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] cnt_reg;
    loop_op_t      op_reg;
    logic          drain_reg;
    logic          pend_reg;
    kind_t         kind_reg;
    logic [CW-1:0] loop_lim;
    logic [CW-1:0] emit_lim;

    // last counter value of a loop pass
    always_comb
    begin
        case (op_reg)
            OP_FWD:  loop_lim = CW'(OUT_DIM - 1);
            OP_BWD:  loop_lim = CW'(IN_DIM - 1);
            OP_UPD:  loop_lim = CW'(NW + OUT_DIM - 1);
            default: loop_lim = CW'(NW - 1);
        endcase
    end

    // last counter value of an emission run
    always_comb
    begin
        case (kind_reg)
            KIND_OUT:   emit_lim = CW'(OUT_DIM - 1);
            KIND_IGRAD: emit_lim = CW'(IN_DIM - 1);
            default:    emit_lim = '0;
        endcase
    end

    // commands
    assign in_stall     = (state_reg != S_IDLE);
    assign cmd.latch    = (state_reg == S_IDLE) && in_valid;
    assign cmd.dispatch = (state_reg == S_DISP);
    assign cmd.issue    = (state_reg == S_LOOP) || (state_reg == S_CLEAR);
    assign cmd.op       = op_reg;
    assign cmd.idx      = cnt_reg;
    assign cmd.emit     = (state_reg == S_EMIT) && status.out_free;
    assign cmd.kind     = kind_reg;
    assign cmd.emit_end = (cnt_reg == emit_lim);

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            op_reg    <= OP_CLR;
            drain_reg <= 1'b0;
            pend_reg  <= 1'b0;
            kind_reg  <= KIND_DONE;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    if (cnt_reg == loop_lim)
                    begin
                        state_reg <= S_DRAIN;
                        drain_reg <= 1'b0;
                        pend_reg  <= 1'b0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    cnt_reg <= '0;
                    case (status.action)
                        ACT_FWD:
                        begin
                            pend_reg <= status.last;
                            kind_reg <= KIND_OUT;
                            op_reg   <= OP_FWD;
                            if (status.rok)
                                state_reg <= S_LOOP;
                            else if (status.last)
                                state_reg <= S_EMIT;
                            else
                                state_reg <= S_IDLE;
                        end
                        ACT_BWD:
                        begin
                            pend_reg <= status.last;
                            kind_reg <= KIND_IGRAD;
                            op_reg   <= OP_BWD;
                            if (status.cok)
                                state_reg <= S_LOOP;
                            else if (status.last)
                                state_reg <= S_EMIT;
                            else
                                state_reg <= S_IDLE;
                        end
                        ACT_UPD:
                        begin
                            pend_reg  <= 1'b1;
                            kind_reg  <= KIND_DONE;
                            op_reg    <= OP_UPD;
                            state_reg <= S_LOOP;
                        end
                        ACT_RD_W:
                        begin
                            kind_reg  <= KIND_WRD;
                            state_reg <= S_EMIT;
                        end
                        ACT_RD_B:
                        begin
                            kind_reg  <= KIND_BRD;
                            state_reg <= S_EMIT;
                        end
                        default:
                            state_reg <= S_IDLE;
                    endcase
                end
                S_LOOP:
                begin
                    if (cnt_reg == loop_lim)
                    begin
                        state_reg <= S_DRAIN;
                        drain_reg <= 1'b0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    // wait for the read and multiply stages to retire
                    if (drain_reg)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= pend_reg ? S_EMIT : S_IDLE;
                    end
                    else
                        drain_reg <= 1'b1;
                end
                S_EMIT:
                begin
                    if (status.out_free)
                    begin
                        if (cnt_reg == emit_lim)
                            state_reg <= S_IDLE;
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/dlte_dp.sv]
// ----------------------------------------------------------------------------
// dlte_dp: datapath of the dense layer training engine
// Weight and gradient memories, small register arrays, a three-stage
// read / multiply / accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module dlte_dp
    import dlte_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [2:0]              action,
    input  logic [3:0]              row_index,
    input  logic [3:0]              col_index,
    input  logic signed [31:0]      value,
    input  logic                    last,
    input  logic                    cfg_we,
    input  logic [LR_W-1:0]         cfg_wdata,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [2:0]              kind,
    output logic [3:0]              index,
    output logic signed [31:0]      result_value,
    output logic                    end_of_run
);

    // latched request and learning rate
    action_t            act_reg;
    logic [3:0]         row_reg;
    logic [3:0]         col_reg;
    logic signed [31:0] val_reg;
    logic               last_reg;
    logic [LR_W-1:0]    lr_reg;
    logic               rok;
    logic               cok;
    logic [AW-1:0]      addr_rc;

    // storage
    logic signed [31:0] w_mem [NW];
    logic signed [31:0] g_mem [NW];
    logic signed [31:0] w_rd;
    logic signed [31:0] g_rd;
    logic signed [31:0] bias_arr  [OUT_DIM];
    logic signed [31:0] bgrad_arr [OUT_DIM];
    logic signed [31:0] acc_arr   [OUT_DIM];
    logic signed [31:0] ig_arr    [IN_DIM];
    logic signed [31:0] sav_arr   [IN_DIM];

    // memory ports
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;
    logic               w_re;
    logic [AW-1:0]      r_addr;
    logic               g_we;
    logic signed [31:0] g_wdata;
    logic [AW-1:0]      loop_addr;

    // pipeline
    logic               s1_valid;
    loop_op_t           s1_op;
    logic [CW-1:0]      s1_idx;
    logic [AW-1:0]      s1_addr;
    logic               s1_bias;
    logic signed [31:0] s1_sav;
    logic               s2_valid;
    loop_op_t           s2_op;
    logic [CW-1:0]      s2_idx;
    logic [AW-1:0]      s2_addr;
    logic               s2_bias;
    logic signed [63:0] s2_p1;
    logic signed [63:0] s2_p2;
    logic signed [31:0] s2_base;
    logic signed [32:0] ma1;
    logic signed [32:0] mb1;
    logic signed [32:0] ma2;
    logic signed [32:0] mb2;
    logic signed [65:0] m1;
    logic signed [65:0] m2;
    logic [CIW-1:0]     s1_bi;
    logic [CIW-1:0]     s2_bi;
    logic signed [63:0] sh_f1;
    logic signed [63:0] sh_f2;
    logic signed [63:0] sh_lr;
    logic signed [31:0] bias_new;

    // result register
    logic               out_valid_reg;
    kind_t              kind_reg;
    logic [3:0]         index_reg;
    logic signed [31:0] value_reg;
    logic               end_reg;
    logic               out_free;
    logic [CIW-1:0]     e_ci;
    logic [RIW-1:0]     e_ri;

    assign rok     = (int'(row_reg) < IN_DIM);
    assign cok     = (int'(col_reg) < OUT_DIM);
    assign addr_rc = AW'(int'(row_reg) * OUT_DIM + int'(col_reg));

    assign status.action   = act_reg;
    assign status.last     = last_reg;
    assign status.rok      = rok;
    assign status.cok      = cok;
    assign status.out_free = out_free;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg  <= action_t'(action);
            row_reg  <= row_index;
            col_reg  <= col_index;
            val_reg  <= value;
            last_reg <= last;
        end
    end

    // learning rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lr_reg <= LR_W'(655);
        else if (cfg_we)
            lr_reg <= cfg_wdata;
    end

    // loop address per operation
    always_comb
    begin
        case (cmd.op)
            OP_FWD:  loop_addr = AW'(int'(row_reg) * OUT_DIM + int'(cmd.idx));
            OP_BWD:  loop_addr = AW'(int'(cmd.idx) * OUT_DIM + int'(col_reg));
            default: loop_addr = AW'(cmd.idx);
        endcase
    end

    assign w_re   = cmd.issue || (cmd.dispatch && (act_reg == ACT_RD_W));
    assign r_addr = cmd.issue ? loop_addr : addr_rc;

    // memories
    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= w_wdata;
        if (w_re)
            w_rd <= w_mem[r_addr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[s2_addr] <= g_wdata;
        if (cmd.issue)
            g_rd <= g_mem[r_addr];
    end

    // stage 1: address and operand capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid <= 1'b0;
            s2_valid <= 1'b0;
        end
        else
        begin
            s1_valid <= cmd.issue;
            s2_valid <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op   <= cmd.op;
        s1_idx  <= cmd.idx;
        s1_addr <= loop_addr;
        s1_bias <= (cmd.op == OP_UPD) && (int'(cmd.idx) >= NW);
        s1_sav  <= sav_arr[RIW'(cmd.idx)];
    end

    assign s1_bi = CIW'(s1_idx - CW'(NW));

    // stage 1 -> 2: multiply
    always_comb
    begin
        ma2 = 33'(val_reg);
        mb2 = 33'(w_rd);
        case (s1_op)
            OP_BWD:
            begin
                ma1 = 33'(s1_sav);
                mb1 = 33'(val_reg);
            end
            OP_UPD:
            begin
                ma1 = 33'($signed({1'b0, lr_reg}));
                mb1 = s1_bias ? 33'(bgrad_arr[s1_bi]) : 33'(g_rd);
            end
            default:
            begin
                ma1 = 33'(val_reg);
                mb1 = 33'(w_rd);
            end
        endcase
        m1 = ma1 * mb1;
        m2 = ma2 * mb2;
    end

    always_ff @(posedge clk)
    begin
        s2_op   <= s1_op;
        s2_idx  <= s1_idx;
        s2_addr <= s1_addr;
        s2_bias <= s1_bias;
        s2_p1   <= m1[63:0];
        s2_p2   <= m2[63:0];
        if (s1_op == OP_BWD)
            s2_base <= g_rd;
        else if (s1_bias)
            s2_base <= bias_arr[s1_bi];
        else
            s2_base <= w_rd;
    end

    // stage 2: shift, accumulate with saturation, write back
    assign s2_bi    = CIW'(s2_idx - CW'(NW));
    assign sh_f1    = s2_p1 >>> FRAC_BITS;
    assign sh_f2    = s2_p2 >>> FRAC_BITS;
    assign sh_lr    = s2_p1 >>> LR_FRAC;
    assign bias_new = sat32(66'(s2_base) - 66'(sh_lr));

    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = s2_addr;
        w_wdata = '0;
        g_we    = 1'b0;
        g_wdata = '0;
        if (s2_valid)
        begin
            case (s2_op)
                OP_CLR:
                begin
                    w_we = 1'b1;
                    g_we = 1'b1;
                end
                OP_UPD:
                begin
                    if (!s2_bias)
                    begin
                        w_we    = 1'b1;
                        w_wdata = sat32(66'(s2_base) - 66'(sh_lr));
                        g_we    = 1'b1;
                    end
                end
                OP_BWD:
                begin
                    g_we    = 1'b1;
                    g_wdata = sat32(66'(s2_base) + 66'(sh_f1));
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.dispatch && (act_reg == ACT_WR_W) && rok && cok)
        begin
            w_we    = 1'b1;
            w_waddr = addr_rc;
            w_wdata = val_reg;
        end
    end

    // saved input row
    always_ff @(posedge clk)
    begin
        if (cmd.dispatch && rok && ((act_reg == ACT_FWD) || (act_reg == ACT_LOAD)))
            sav_arr[RIW'(row_reg)] <= val_reg;
    end

    assign e_ci = CIW'(cmd.idx);
    assign e_ri = RIW'(cmd.idx);

    // bias, gradient and accumulator arrays
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < OUT_DIM; j++)
            begin
                bias_arr[j]  <= '0;
                bgrad_arr[j] <= '0;
                acc_arr[j]   <= '0;
            end
            for (int i = 0; i < IN_DIM; i++)
                ig_arr[i] <= '0;
        end
        else
        begin
            if (cmd.dispatch && cok && (act_reg == ACT_WR_B))
                bias_arr[CIW'(col_reg)] <= val_reg;
            if (cmd.dispatch && cok && (act_reg == ACT_BWD))
                bgrad_arr[CIW'(col_reg)] <=
                    sat32(66'(bgrad_arr[CIW'(col_reg)]) + 66'(val_reg));
            if (s2_valid)
            begin
                case (s2_op)
                    OP_FWD:
                        acc_arr[CIW'(s2_idx)] <=
                            sat32(66'(acc_arr[CIW'(s2_idx)]) + 66'(sh_f1));
                    OP_BWD:
                        ig_arr[RIW'(s2_idx)] <=
                            sat32(66'(ig_arr[RIW'(s2_idx)]) + 66'(sh_f2));
                    OP_UPD:
                    begin
                        if (s2_bias)
                        begin
                            bias_arr[s2_bi]  <= bias_new;
                            bgrad_arr[s2_bi] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // emission clears the accumulator it reads
            if (cmd.emit && (cmd.kind == KIND_OUT))
                acc_arr[e_ci] <= '0;
            if (cmd.emit && (cmd.kind == KIND_IGRAD))
                ig_arr[e_ri] <= '0;
        end
    end

    // result register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.kind;
            end_reg  <= cmd.emit_end;
            case (cmd.kind)
                KIND_OUT:
                begin
                    index_reg <= 4'(cmd.idx);
                    value_reg <= sat32(66'(acc_arr[e_ci]) + 66'(bias_arr[e_ci]));
                end
                KIND_IGRAD:
                begin
                    index_reg <= 4'(cmd.idx);
                    value_reg <= ig_arr[e_ri];
                end
                KIND_WRD:
                begin
                    index_reg <= col_reg;
                    value_reg <= (rok && cok) ? w_rd : '0;
                end
                KIND_BRD:
                begin
                    index_reg <= col_reg;
                    value_reg <= cok ? bias_arr[CIW'(col_reg)] : '0;
                end
                default:
                begin
                    index_reg <= '0;
                    value_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign index        = index_reg;
    assign result_value = value_reg;
    assign end_of_run   = end_reg;

endmodule

[rtl/core/dense_layer_train_engine.sv]
// ----------------------------------------------------------------------------
// dense_layer_train_engine: fully connected layer with SGD training
// Q16.16 forward, backward and update passes over a 16 x 16 weight table.
// ----------------------------------------------------------------------------
// One request is handled at a time; results leave through a one-deep output
// register. After reset the weight and gradient memories are cleared by a pass
// over all IN_DIM*OUT_DIM entries during which no request is taken. Write,
// load and bias-write requests finish at dispatch. A forward element walks
// OUT_DIM weights and a backward element IN_DIM, one multiply-accumulate
// per cycle through the single read port of the weight memory; a last mark
// adds the emission of the accumulated results. Update walks all weights and
// biases. A stalled output holds back every emitted result.
module dense_layer_train_engine
    import dlte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [3:0]         row_index,
    input  logic [3:0]         col_index,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [3:0]         index,
    output logic signed [31:0] result_value,
    output logic               end_of_run,
    input  logic               cfg_we,
    input  logic [LR_W-1:0]    cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    dlte_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    dlte_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .kind         (kind),
        .index        (index),
        .result_value (result_value),
        .end_of_run   (end_of_run)
    );

endmodule

[dv/tb_dense_layer_train_engine.sv]
// ----------------------------------------------------------------------------
// tb_dense_layer_train_engine: self-checking bench for the dense layer engine
// Drives forward, backward, update, write and read requests with random
// gaps and output stalls. A scoreboard predicts every result in Q16.16.
// ----------------------------------------------------------------------------
module tb_dense_layer_train_engine
    import dlte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // one expected result
    typedef struct {
        kind_t              kind;
        logic [3:0]         index;
        logic signed [31:0] result_value;
        logic               end_of_run;
    } layer_result_t;

    // layer state mirror and queue of expected results
    class layer_scoreboard;
        longint         weight_mem [NW];
        longint         bias_mem [OUT_DIM];
        longint         weight_grad [NW];
        longint         bias_grad [OUT_DIM];
        longint         saved_x [IN_DIM];
        longint         out_acc [OUT_DIM];
        longint         igrad_acc [IN_DIM];
        longint         rate;
        layer_result_t  pending [$];
        int             mismatches;
        int             checked;

        function new();
            foreach (weight_mem[i])
            begin
                weight_mem[i] = 0;
                weight_grad[i] = 0;
            end
            foreach (bias_mem[i])
            begin
                bias_mem[i] = 0;
                bias_grad[i] = 0;
                out_acc[i] = 0;
            end
            foreach (saved_x[i])
            begin
                saved_x[i] = 0;
                igrad_acc[i] = 0;
            end
            rate = 655;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // >>> on a signed longint floors toward minus infinity
        function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC_BITS;
        endfunction

        function void push(kind_t k, int idx, longint v, bit e);
            layer_result_t r;
            r.kind = k;
            r.index = idx[3:0];
            r.result_value = v[31:0];
            r.end_of_run = e;
            pending.push_back(r);
        endfunction

        function void note_request(action_t act, int row, int col, longint v, bit lst);
            longint d;
            case (act)
                ACT_WR_W: weight_mem[row * OUT_DIM + col] = v;
                ACT_WR_B: bias_mem[col] = v;
                ACT_LOAD: saved_x[row] = v;
                ACT_FWD:
                begin
                    saved_x[row] = v;
                    for (int j = 0; j < OUT_DIM; j++)
                        out_acc[j] = clamp32(out_acc[j] + qmul(v, weight_mem[row * OUT_DIM + j]));
                    if (lst)
                        for (int j = 0; j < OUT_DIM; j++)
                        begin
                            push(KIND_OUT, j, clamp32(out_acc[j] + bias_mem[j]), j == OUT_DIM - 1);
                            out_acc[j] = 0;
                        end
                end
                ACT_BWD:
                begin
                    bias_grad[col] = clamp32(bias_grad[col] + v);
                    for (int i = 0; i < IN_DIM; i++)
                    begin
                        weight_grad[i * OUT_DIM + col] =
                            clamp32(weight_grad[i * OUT_DIM + col] + qmul(saved_x[i], v));
                        igrad_acc[i] =
                            clamp32(igrad_acc[i] + qmul(v, weight_mem[i * OUT_DIM + col]));
                    end
                    if (lst)
                        for (int i = 0; i < IN_DIM; i++)
                        begin
                            push(KIND_IGRAD, i, igrad_acc[i], i == IN_DIM - 1);
                            igrad_acc[i] = 0;
                        end
                end
                ACT_UPD:
                begin
                    for (int i = 0; i < NW; i++)
                    begin
                        d = (rate * weight_grad[i]) >>> LR_FRAC;
                        weight_mem[i] = clamp32(weight_mem[i] - d);
                        weight_grad[i] = 0;
                    end
                    for (int j = 0; j < OUT_DIM; j++)
                    begin
                        d = (rate * bias_grad[j]) >>> LR_FRAC;
                        bias_mem[j] = clamp32(bias_mem[j] - d);
                        bias_grad[j] = 0;
                    end
                    push(KIND_DONE, 0, 0, 1'b1);
                end
                ACT_RD_W: push(KIND_WRD, col, weight_mem[row * OUT_DIM + col], 1'b1);
                default: push(KIND_BRD, col, bias_mem[col], 1'b1);
            endcase
        endfunction

        function void check_result(logic [2:0] k, logic [3:0] idx, logic [31:0] v, logic e);
            layer_result_t x;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d index=%0d value=%h end=%b",
                             k, idx, v, e);
                return;
            end
            x = pending.pop_front();
            if (k !== x.kind || idx !== x.index || v !== x.result_value || e !== x.end_of_run)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result exp kind=%0d idx=%0d val=%h end=%b, got %0d %0d %h %b",
                             x.kind, x.index, x.result_value, x.end_of_run, k, idx, v, e);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] value;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         kind;
    logic [3:0]         index;
    logic signed [31:0] result_value;
    logic               end_of_run;
    logic               cfg_we;
    logic [LR_W-1:0]    cfg_wdata;

    layer_scoreboard    sb;
    int                 req_count;

    dense_layer_train_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .index        (index),
        .result_value (result_value),
        .end_of_run   (end_of_run),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 clk = ~clk;

    // send one request after a random gap; no_gap raises valid at the next falling
    // edge, which the engine's dispatch cycle hides anyway
    task automatic send_request(action_t act, int row, int col, logic [31:0] v, bit lst,
                                bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        repeat (gap + 1) @(negedge clk);
        in_valid  <= 1'b1;
        action    <= act;
        row_index <= row[3:0];
        col_index <= col[3:0];
        value     <= v;
        last      <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, row, col, $signed(v), lst);
        req_count++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // write learn_rate while the engine is idle
    task automatic set_rate(logic [LR_W-1:0] r);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.rate = r;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h3ffff) - 32'h20000;
        endcase
    endfunction

    // forward rows, random loads, gradient rows and an optional update, with random content
    task automatic train_step();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            send_request(ACT_FWD, $urandom_range(0, 15), 0, rand_value(), i == n - 1);
        for (int i = 0; i < IN_DIM; i++)
            if ($urandom_range(0, 3) == 0)
                send_request(ACT_LOAD, i, 0, rand_value(), 0);
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            send_request(ACT_BWD, $urandom_range(0, 15), $urandom_range(0, 15), rand_value(),
                         i == n - 1);
        if ($urandom_range(0, 1))
            send_request(ACT_UPD, 0, 0, rand_value(), 0);
    endtask

    // result side: random wait before each result, sample at rising edge
    initial
    begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, 14);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result(kind, index, result_value, end_of_run);
        end
    end

    // stimulus
    initial
    begin
        int wait_cycles;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_WR_W;
        row_index = '0;
        col_index = '0;
        value = '0;
        last = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_count = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // every saved input is defined before any backward pass
        for (int i = 0; i < IN_DIM; i++)
            send_request(ACT_LOAD, i, 0, rand_value(), 0);

        // directed: extremes, every action, index edges
        send_request(ACT_RD_W, 15, 15, 0, 0);
        send_request(ACT_RD_B, 0, 15, 0, 0);
        send_request(ACT_WR_W, 0, 0, 32'h7fffffff, 0);
        send_request(ACT_WR_W, 15, 15, 32'h80000000, 0);
        send_request(ACT_WR_W, 15, 0, 32'h00010000, 0);
        send_request(ACT_WR_B, 0, 0, 32'h7fffffff, 0);
        send_request(ACT_WR_B, 0, 15, 32'h80000000, 0);
        send_request(ACT_FWD, 0, 0, 32'h7fffffff, 0);
        send_request(ACT_FWD, 15, 0, 32'h80000000, 1);
        send_request(ACT_LOAD, 0, 0, 32'hffffffff, 0);
        send_request(ACT_BWD, 0, 15, 32'h7fffffff, 0);
        send_request(ACT_BWD, 0, 0, 32'h80000000, 1);
        send_request(ACT_RD_B, 0, 0, 0, 0);
        send_request(ACT_UPD, 0, 0, 0, 0);
        send_request(ACT_RD_W, 0, 0, 0, 0);
        send_request(ACT_RD_W, 15, 15, 0, 0);
        send_request(ACT_RD_B, 15, 15, 32'hffffffff, 1);
        // back-to-back requests with no gap
        send_request(ACT_WR_W, 5, 10, 32'h55555555, 1, 1);
        send_request(ACT_RD_W, 5, 10, 32'haaaaaaaa, 0, 1);
        // learning-rate extremes
        set_rate(0);
        train_step();
        set_rate(20'hfffff);
        train_step();
        send_request(ACT_UPD, 0, 0, 0, 0);
        set_rate(1);

        // random mix, half of it well formed training steps
        while (req_count < 120)
        begin
            case ($urandom_range(0, 9))
                0: send_request(ACT_WR_W, $urandom_range(0, 15), $urandom_range(0, 15),
                                rand_value(), $urandom_range(0, 1));
                1: send_request(ACT_WR_B, 0, $urandom_range(0, 15), rand_value(), 0);
                2: send_request(ACT_RD_W, $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom(), $urandom_range(0, 1));
                3: send_request(ACT_RD_B, $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom(), 0);
                4: set_rate(LR_W'($urandom_range(0, 20'hfffff)));
                default: train_step();
            endcase
        end

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (400) @(negedge clk);
        $display("Run covered %0d requests and %0d checked results, incl. saturation and rates",
                 req_count, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_dense_layer_train_engine passed");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("tb_dense_layer_train_engine failed");
        end
        $finish;
    end

    // overall time limit
    initial
    begin
        #50ms;
        $display("Timeout");
        $display("tb_dense_layer_train_engine failed");
        $finish;
    end

endmodule

[dense_layer_train_engine.f]
rtl/core/dlte_pkg.sv
rtl/core/dlte_ctrl.sv
rtl/core/dlte_dp.sv
rtl/core/dense_layer_train_engine.sv
dv/tb_dense_layer_train_engine.sv
